>>> rtl/rsws_pkg.sv
`default_nettype none
package rsws_pkg;

    localparam int KEY_W     = 31;
    localparam int BAL_W     = 40;
    localparam int THR_W     = 39;
    localparam int CNT_W     = 5;
    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 160;
    localparam int M_TUSER_W = 2;

    // 100000 units of 100 cents
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(100000 * 100);

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             kind;
        logic [BAL_W-1:0] bal;
    } rec_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_STATS,
        ST_SEL,
        ST_EMIT,
        ST_EMPTY
    } state_t;

    typedef enum logic {
        SCAN_STATS,
        SCAN_SELECT
    } scan_mode_t;

    typedef struct packed {
        logic       load_write;
        logic       load_drop;
        logic       scan_start;
        scan_mode_t scan_mode;
        logic       advance;
        logic       clear_batch;
        logic       out_empty;
    } cmd_t;

    typedef struct packed {
        logic key_zero;
        logic held_zero;
        logic full;
        logic scan_done;
        logic all_emitted;
    } sts_t;

endpackage
`default_nettype wire

>>> rtl/rsws_dpath.sv
`default_nettype none
module rsws_dpath #(
    parameter int CAPACITY = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [rsws_pkg::S_TDATA_W-1:0]  in_data,
    input  wire logic                            in_kind,
    input  wire logic                            cfg_wr_en,
    input  wire logic [rsws_pkg::THR_W-1:0]      cfg_wr_data,
    input  wire rsws_pkg::cmd_t                  cmd,
    output rsws_pkg::sts_t                       sts,
    output logic      [rsws_pkg::M_TDATA_W-1:0]  out_data,
    output logic      [rsws_pkg::M_TUSER_W-1:0]  out_user
);
    import rsws_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    rec_t store_mem [CAPACITY];

    logic [THR_W-1:0] thr_reg;
    logic [CW-1:0]    held_count_reg;
    logic             dropped_reg;

    logic [IW-1:0]    scan_addr_reg;
    logic             scan_busy_reg;
    scan_mode_t       mode_reg;
    logic             scan_last;

    rec_t             rd_data_reg;
    logic [IW-1:0]    rd_idx_reg;
    logic             rd_vld_reg;
    logic             rd_last_reg;

    logic [CW-1:0]    neg_reg, neg_next;
    logic [CW-1:0]    above_reg, above_next;
    logic             min_found_reg, min_found_next;
    rec_t             min_rec_reg, min_rec_next;

    logic             best_found_reg, best_found_next;
    rec_t             best_rec_reg, best_rec_next;
    logic [IW-1:0]    best_idx_reg, best_idx_next;

    logic             first_out_reg;
    logic [KEY_W-1:0] prev_key_reg;
    logic [IW-1:0]    prev_idx_reg;
    logic [CW-1:0]    emitted_reg;

    rec_t             in_rec;
    logic signed [BAL_W-1:0] cur_bal;
    logic signed [BAL_W-1:0] min_bal;
    logic             cand;

    assign in_rec.key  = in_data[KEY_W-1:0];
    assign in_rec.kind = in_kind;
    assign in_rec.bal  = in_data[KEY_W+BAL_W-1:KEY_W];

    assign scan_last = (CW'(scan_addr_reg) == (held_count_reg - CW'(1)));

    // store: write at the fill position, read one entry a cycle during scans
    always_ff @(posedge clk)
    begin
        if (cmd.load_write)
        begin
            store_mem[held_count_reg[IW-1:0]] <= in_rec;
        end
        if (scan_busy_reg)
        begin
            rd_data_reg <= store_mem[scan_addr_reg];
        end
        rd_idx_reg <= scan_addr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= THR_RESET;
            held_count_reg <= '0;
            dropped_reg    <= 1'b0;
            scan_addr_reg  <= '0;
            scan_busy_reg  <= 1'b0;
            mode_reg       <= SCAN_STATS;
            rd_vld_reg     <= 1'b0;
            rd_last_reg    <= 1'b0;
            min_found_reg  <= 1'b0;
            best_found_reg <= 1'b0;
            first_out_reg  <= 1'b1;
            emitted_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
            if (cmd.load_write)
            begin
                held_count_reg <= held_count_reg + CW'(1);
            end
            if (cmd.load_drop)
            begin
                dropped_reg <= 1'b1;
            end
            if (cmd.clear_batch)
            begin
                held_count_reg <= '0;
                dropped_reg    <= 1'b0;
                first_out_reg  <= 1'b1;
                emitted_reg    <= '0;
            end
            if (cmd.advance)
            begin
                first_out_reg <= 1'b0;
                emitted_reg   <= emitted_reg + CW'(1);
            end

            if (cmd.scan_start)
            begin
                scan_addr_reg <= '0;
                scan_busy_reg <= 1'b1;
                mode_reg      <= cmd.scan_mode;
            end
            else if (scan_busy_reg)
            begin
                if (scan_last)
                begin
                    scan_busy_reg <= 1'b0;
                end
                else
                begin
                    scan_addr_reg <= scan_addr_reg + IW'(1);
                end
            end
            rd_vld_reg     <= scan_busy_reg;
            rd_last_reg    <= scan_busy_reg & scan_last;
            min_found_reg  <= min_found_next;
            best_found_reg <= best_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg      <= neg_next;
        above_reg    <= above_next;
        min_rec_reg  <= min_rec_next;
        best_rec_reg <= best_rec_next;
        best_idx_reg <= best_idx_next;
        if (cmd.advance)
        begin
            prev_key_reg <= best_rec_reg.key;
            prev_idx_reg <= best_idx_reg;
        end
    end

    // scan accumulators
    always_comb
    begin
        neg_next        = neg_reg;
        above_next      = above_reg;
        min_found_next  = min_found_reg;
        min_rec_next    = min_rec_reg;
        best_found_next = best_found_reg;
        best_rec_next   = best_rec_reg;
        best_idx_next   = best_idx_reg;
        cur_bal         = $signed(rd_data_reg.bal);
        min_bal         = $signed(min_rec_reg.bal);
        cand            = first_out_reg
                        || (rd_data_reg.key > prev_key_reg)
                        || ((rd_data_reg.key == prev_key_reg) && (rd_idx_reg > prev_idx_reg));

        if (cmd.scan_start)
        begin
            if (cmd.scan_mode == SCAN_STATS)
            begin
                neg_next       = '0;
                above_next     = '0;
                min_found_next = 1'b0;
            end
            else
            begin
                best_found_next = 1'b0;
            end
        end

        if (rd_vld_reg)
        begin
            if (mode_reg == SCAN_STATS)
            begin
                if (cur_bal < 0)
                begin
                    neg_next = neg_reg + CW'(1);
                end
                else if (rd_data_reg.bal[THR_W-1:0] > thr_reg)
                begin
                    above_next = above_reg + CW'(1);
                end
                // smallest balance; ties go to the smaller key (earlier in sorted order)
                if (!min_found_reg || (cur_bal < min_bal)
                    || ((cur_bal == min_bal) && (rd_data_reg.key < min_rec_reg.key)))
                begin
                    min_found_next = 1'b1;
                    min_rec_next   = rd_data_reg;
                end
            end
            else
            begin
                // next record after the previous one in (key, arrival) order
                if (cand && (!best_found_reg || (rd_data_reg.key < best_rec_reg.key)))
                begin
                    best_found_next = 1'b1;
                    best_rec_next   = rd_data_reg;
                    best_idx_next   = rd_idx_reg;
                end
            end
        end
    end

    always_comb
    begin
        sts.key_zero    = (in_rec.key == '0);
        sts.held_zero   = (held_count_reg == '0);
        sts.full        = (held_count_reg == CW'(CAPACITY));
        sts.scan_done   = rd_vld_reg & rd_last_reg;
        sts.all_emitted = ((emitted_reg + CW'(1)) == held_count_reg);
    end

    always_comb
    begin
        if (cmd.out_empty)
        begin
            out_data = '0;
            out_data[M_TDATA_W-2] = dropped_reg;
            out_user = '0;
        end
        else
        begin
            out_data = {1'b0, dropped_reg, CNT_W'(held_count_reg), CNT_W'(above_reg),
                        CNT_W'(neg_reg), min_rec_reg.bal, min_rec_reg.kind, min_rec_reg.key,
                        best_rec_reg.bal, best_rec_reg.key};
            out_user = {1'b1, best_rec_reg.kind};
        end
    end

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg <= CW'(CAPACITY))
        else $error("held count beyond capacity");

    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_write |-> (held_count_reg != CW'(CAPACITY)) && !cmd.load_drop)
        else $error("store write while full");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_start |-> (held_count_reg != '0))
        else $error("scan started on empty store");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (CW'(rd_idx_reg) < held_count_reg))
        else $error("read beyond held records");
`endif

endmodule
`default_nettype wire

>>> rtl/rsws_ctrl.sv
`default_nettype none
module rsws_ctrl (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  wire logic      m_tready,
    output logic           m_tlast,
    input  wire rsws_pkg::sts_t sts,
    output rsws_pkg::cmd_t cmd
);
    import rsws_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        m_tlast    = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (sts.key_zero)
                    begin
                        if (sts.held_zero)
                        begin
                            state_next = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            cmd.scan_mode  = SCAN_STATS;
                            state_next     = ST_STATS;
                        end
                    end
                    else if (sts.full)
                    begin
                        cmd.load_drop = 1'b1;
                    end
                    else
                    begin
                        cmd.load_write = 1'b1;
                    end
                end
            end
            ST_STATS:
            begin
                if (sts.scan_done)
                begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_mode  = SCAN_SELECT;
                    state_next     = ST_SEL;
                end
            end
            ST_SEL:
            begin
                if (sts.scan_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                m_tvalid = 1'b1;
                m_tlast  = sts.all_emitted;
                if (m_tready)
                begin
                    if (sts.all_emitted)
                    begin
                        cmd.clear_batch = 1'b1;
                        state_next      = ST_LOAD;
                    end
                    else
                    begin
                        cmd.advance    = 1'b1;
                        cmd.scan_start = 1'b1;
                        cmd.scan_mode  = SCAN_SELECT;
                        state_next     = ST_SEL;
                    end
                end
            end
            ST_EMPTY:
            begin
                m_tvalid      = 1'b1;
                m_tlast       = 1'b1;
                cmd.out_empty = 1'b1;
                if (m_tready)
                begin
                    cmd.clear_batch = 1'b1;
                    state_next      = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/record_sort_with_statistics.sv
// Loading: one record a request; a zero key closes the batch.
// Batch of n records: a statistics pass over the store, then for each output a
// selection pass over the single read port of the store, plus a result
// handshake per output; input stalls meanwhile.
// Empty batch: one invalid result in the cycle after the terminator.
// Reset (async, active low): held and emitted counts and most flags clear, threshold to 10000000; store not cleared.
`default_nettype none
module record_sort_with_statistics #(
    parameter int CAPACITY = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // input request stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [30:0] account_key, [70:31] balance_cents, [71] zero
    input  wire logic [rsws_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] account_kind
    input  wire logic [rsws_pkg::S_TUSER_W-1:0] s_tuser,
    // result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [30:0] rec_key, [70:31] rec_balance, [101:71] min_key, [102] min_kind,
    // [142:103] min_balance, [147:143] negative_count, [152:148] above_count,
    // [157:153] record_count, [158] overflow, [159] zero
    output logic      [rsws_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] rec_kind, [1] rec_valid
    output logic      [rsws_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                                m_tlast,
    // threshold register write
    input  wire logic                           cfg_wr_en,
    input  wire logic [rsws_pkg::THR_W-1:0]     cfg_wr_data
);
    import rsws_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer: load, statistics pass, selection passes, result handshakes
    rsws_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .sts      (sts),
        .cmd      (cmd)
    );

    // store, scan counter, accumulators and result registers
    rsws_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_data     (s_tdata),
        .in_kind     (s_tuser[0]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts),
        .out_data    (m_tdata),
        .out_user    (m_tuser)
    );

endmodule
`default_nettype wire

>>> sim/record_sort_with_statistics_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module record_sort_with_statistics_tb;
    import rsws_pkg::*;

    localparam int CAP           = 16;
    localparam int RANDOM_ITEMS  = 120;
    localparam int PHASES        = 4;
    // idle cycles after the final result before the threshold moves
    localparam int SETTLE_CYCLES = 8;
    // extra wait at the end, after the last expected result has arrived
    localparam int TAIL_CYCLES   = 320;
    localparam int CYCLE_LIMIT   = 200000;

    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
    localparam logic [BAL_W-1:0] BAL_MIN = {1'b1, {(BAL_W-1){1'b0}}};
    localparam logic [BAL_W-1:0] BAL_MAX = {1'b0, {(BAL_W-1){1'b1}}};
    localparam logic [THR_W-1:0] THR_MAX = {THR_W{1'b1}};

    // one emitted result, field by field
    typedef struct packed {
        rec_t             rec;
        logic             rec_valid;
        logic             last;
        rec_t             min_rec;
        logic [CNT_W-1:0] neg_cnt;
        logic [CNT_W-1:0] above_cnt;
        logic [CNT_W-1:0] rec_cnt;
        logic             overflow;
    } sorted_out_t;

    // directed row: a request, plus a hand-written result where one is obvious
    typedef struct {
        rec_t        rec;
        bit          typed;
        sorted_out_t want;
    } stim_row_t;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic [S_TUSER_W-1:0] s_tuser     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;
    logic                 cfg_wr_en   = 1'b0;
    logic [THR_W-1:0]     cfg_wr_data = '0;

    // predictor state: the batch being loaded, the drop flag, the threshold
    rec_t             held_recs[$];
    logic             dropped = 1'b0;
    logic [THR_W-1:0] thr_now = THR_RESET;

    sorted_out_t      expected_results[$];
    stim_row_t        stim_table[$];

    int  fail_count       = 0;
    int  requests_sent    = 0;
    int  results_checked  = 0;
    int  batches_closed   = 0;
    int  overflow_batches = 0;
    int  empty_batches    = 0;
    int  thr_writes       = 0;
    int  cycle_count      = 0;
    int  ready_hold       = 0;
    bit  calm             = 1'b0;

    record_sort_with_statistics #(
        .CAPACITY(CAP)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("Run stopped: cycle limit of %0d reached", CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    // In a calm stretch there are none at all.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm)
            return 0;
        else if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Result-side back-pressure. Only one update of m_tready per edge.
    always @(posedge clk)
    begin : sink_pacing
        int stall;
        if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
        end
        else if (calm)
        begin
            m_tready <= 1'b1;
        end
        else
        begin
            stall = pick_gap();
            if (stall == 0)
            begin
                m_tready   <= 1'b1;
                ready_hold <= $urandom_range(0, 6);
            end
            else
            begin
                m_tready   <= 1'b0;
                ready_hold <= stall - 1;
            end
        end
    end

    // Predictor: feed it each accepted request. Data requests are stored
    // (or dropped once full); a zero key closes the batch, which is then
    // sorted stably by key and turned into one expected result per record.
    task automatic absorb_request(input rec_t r);
        sorted_out_t o;
        rec_t        tmp;
        int          n;
        int          minpos;
        int          neg;
        int          above;
        if (r.key != '0)
        begin
            if (held_recs.size() < CAP)
                held_recs.push_back(r);
            else
                dropped = 1'b1;
        end
        else
        begin
            batches_closed++;
            if (dropped)
                overflow_batches++;
            n = held_recs.size();
            if (n == 0)
            begin
                // empty batch: one invalid result, only last and overflow set
                empty_batches++;
                o          = '0;
                o.last     = 1'b1;
                o.overflow = dropped;
                expected_results.push_back(o);
            end
            else
            begin
                // bubble sort, strict compare keeps equal keys in arrival order
                for (int p = 0; p < n; p++)
                    for (int j = 0; j + 1 < n; j++)
                        if (held_recs[j].key > held_recs[j+1].key)
                        begin
                            tmp            = held_recs[j];
                            held_recs[j]   = held_recs[j+1];
                            held_recs[j+1] = tmp;
                        end
                minpos = 0;
                neg    = 0;
                above  = 0;
                for (int i = 0; i < n; i++)
                begin
                    // strict less-than: first smallest in sorted order wins
                    if ($signed(held_recs[i].bal) < $signed(held_recs[minpos].bal))
                        minpos = i;
                    if (held_recs[i].bal[BAL_W-1])
                        neg++;
                    else if (held_recs[i].bal > {1'b0, thr_now})
                        above++;
                end
                for (int i = 0; i < n; i++)
                begin
                    o.rec       = held_recs[i];
                    o.rec_valid = 1'b1;
                    o.last      = (i == n - 1);
                    o.min_rec   = held_recs[minpos];
                    o.neg_cnt   = CNT_W'(neg);
                    o.above_cnt = CNT_W'(above);
                    o.rec_cnt   = CNT_W'(n);
                    o.overflow  = dropped;
                    expected_results.push_back(o);
                end
            end
            held_recs.delete();
            dropped = 1'b0;
        end
    endtask

    // Present one request and hold it until accepted. The valid stays high
    // on return so that a back-to-back request needs no second write.
    task automatic drive_request(input rec_t r, input bit typed, input sorted_out_t want);
        int gap;
        int n0;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, r.bal, r.key};
        s_tuser  <= r.kind;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        requests_sent++;
        n0 = expected_results.size();
        absorb_request(r);
        if (typed)
        begin
            // hand-written result replaces the predicted one
            while (expected_results.size() > n0)
                void'(expected_results.pop_back());
            expected_results.push_back(want);
        end
    endtask

    // Threshold writes happen only once the block has drained.
    task automatic set_threshold(input logic [THR_W-1:0] v);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        thr_now   = v;
        thr_writes++;
    endtask

    function automatic sorted_out_t single_result(input rec_t rec, input logic valid,
                                                  input int neg, input int above);
        sorted_out_t o;
        o           = '0;
        o.rec       = rec;
        o.rec_valid = valid;
        o.last      = 1'b1;
        o.min_rec   = rec;
        o.neg_cnt   = CNT_W'(neg);
        o.above_cnt = CNT_W'(above);
        o.rec_cnt   = CNT_W'(valid ? 1 : 0);
        return o;
    endfunction

    task automatic add_row(input logic [KEY_W-1:0] key, input logic kind,
                           input logic [BAL_W-1:0] bal, input bit typed,
                           input sorted_out_t want);
        stim_row_t row;
        row.rec.key  = key;
        row.rec.kind = kind;
        row.rec.bal  = bal;
        row.typed    = typed;
        row.want     = want;
        stim_table.push_back(row);
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endfunction

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        sorted_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result arrived with nothing expected: tdata %h tuser %h",
                       m_tdata, m_tuser);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                check_field("rec_key",        64'(want.rec.key),      64'(m_tdata[30:0]));
                check_field("rec_kind",       64'(want.rec.kind),     64'(m_tuser[0]));
                check_field("rec_balance",    64'(want.rec.bal),      64'(m_tdata[70:31]));
                check_field("rec_valid",      64'(want.rec_valid),    64'(m_tuser[1]));
                check_field("last",           64'(want.last),         64'(m_tlast));
                check_field("min_key",        64'(want.min_rec.key),  64'(m_tdata[101:71]));
                check_field("min_kind",       64'(want.min_rec.kind), 64'(m_tdata[102]));
                check_field("min_balance",    64'(want.min_rec.bal),  64'(m_tdata[142:103]));
                check_field("negative_count", 64'(want.neg_cnt),      64'(m_tdata[147:143]));
                check_field("above_count",    64'(want.above_cnt),    64'(m_tdata[152:148]));
                check_field("record_count",   64'(want.rec_cnt),      64'(m_tdata[157:153]));
                check_field("overflow",       64'(want.overflow),     64'(m_tdata[158]));
            end
        end
    end

    initial
    begin : stimulus
        rec_t             r;
        rec_t             extreme;
        logic [THR_W-1:0] thr_plan[PHASES];
        int               nrec;
        int               roll;
        int               phase_sent;

        // --- directed table ---
        // empty batch straight after reset
        add_row('0, 1'b0, '0, 1'b1, single_result('0, 1'b0, 0, 0));
        // largest key, checking, most negative balance
        extreme = '{key: KEY_MAX, kind: 1'b1, bal: BAL_MIN};
        add_row(extreme.key, extreme.kind, extreme.bal, 1'b0, '0);
        add_row('0, 1'b0, '0, 1'b1, single_result(extreme, 1'b1, 1, 0));
        // smallest key, savings, most positive balance (above the reset threshold)
        extreme = '{key: KEY_W'(1), kind: 1'b0, bal: BAL_MAX};
        add_row(extreme.key, extreme.kind, extreme.bal, 1'b0, '0);
        add_row('0, 1'b0, '0, 1'b1, single_result(extreme, 1'b1, 0, 1));
        // one more than capacity: falling keys with repeats, a repeated
        // smallest balance, and the last record dropped
        for (int i = 0; i <= CAP; i++)
            add_row(KEY_W'(5 - (i % 5)), i[0],
                    (i % 4 == 1) ? -BAL_W'(5) : BAL_W'(i * 2500000), 1'b0, '0);
        add_row('0, 1'b0, '0, 1'b0, '0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
            drive_request(stim_table[i].rec, stim_table[i].typed, stim_table[i].want);

        // --- random batches under several thresholds ---
        thr_plan[0] = '0;
        thr_plan[1] = THR_MAX;
        thr_plan[2] = THR_W'({$urandom, $urandom});
        thr_plan[3] = THR_W'($urandom_range(0, 20000000));

        for (int ph = 0; ph < PHASES; ph++)
        begin
            set_threshold(thr_plan[ph]);
            phase_sent = 0;
            while (phase_sent < RANDOM_ITEMS / PHASES)
            begin
                calm = ($urandom_range(0, 5) == 0);
                // mostly short batches; a few empty, full or overfull ones
                roll = $urandom_range(0, 99);
                if (roll < 8)
                    nrec = 0;
                else if (roll < 80)
                    nrec = $urandom_range(1, 5);
                else if (roll < 92)
                    nrec = $urandom_range(6, CAP - 1);
                else if (roll < 97)
                    nrec = CAP;
                else
                    nrec = $urandom_range(CAP + 1, CAP + 3);

                for (int k = 0; k < nrec; k++)
                begin
                    // small keys give plenty of ties for the stability check
                    if ($urandom_range(0, 3) == 0)
                        r.key = KEY_W'($urandom);
                    else
                        r.key = KEY_W'($urandom_range(1, 8));
                    if (r.key == '0)
                        r.key = KEY_W'(1);
                    r.kind = 1'($urandom);
                    case ($urandom_range(0, 5))
                        0, 1:    r.bal = BAL_W'({$urandom, $urandom});
                        2:       r.bal = BAL_W'($urandom_range(0, 200)) - BAL_W'(100);
                        // straddle the threshold
                        3:       r.bal = BAL_W'({1'b0, thr_now})
                                         + BAL_W'($urandom_range(0, 2)) - BAL_W'(1);
                        4:       r.bal = $urandom_range(0, 1) ? BAL_MIN : BAL_MAX;
                        default: r.bal = BAL_W'($urandom_range(0, 30000000));
                    endcase
                    drive_request(r, 1'b0, '0);
                    phase_sent++;
                end

                // closing request; its other fields are don't-care but driven
                r.key  = '0;
                r.kind = 1'($urandom);
                r.bal  = BAL_W'({$urandom, $urandom});
                drive_request(r, 1'b0, '0);
                phase_sent++;
            end
        end

        s_tvalid <= 1'b0;
        calm = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d requests in %0d batches (%0d empty, %0d overflowed)",
                 requests_sent, batches_closed, empty_batches, overflow_batches);
        $display("%0d results checked over %0d threshold settings, %0d failures",
                 results_checked, thr_writes + 1, fail_count);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire
